// File: hdl/kwu_pkg.sv
// ----------------------------------------------------------------------------
// kwu_pkg
// Shared types and constants of the Kruskal wall union engine: field
// widths, operation and status codes, and the command that goes from the
// front part through the queue to the back part.
// ----------------------------------------------------------------------------
package kwu_pkg;

  localparam int NUM_CELLS_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CELL_W   = 10;
  localparam int TAG_W    = 11;
  localparam int STATUS_W = 2;

  // operation field codes
  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_WALL    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_BOUNDARY = 2'd0,
    ST_KEPT     = 2'd1,
    ST_MERGED   = 2'd2,
    ST_RESTART  = 2'd3
  } kwu_status_e;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_SKIP    = 2'd1,
    CMD_WALL    = 2'd2
  } kwu_cmd_e;

  typedef struct packed {
    kwu_cmd_e          kind;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
    logic [TAG_W-1:0]  tag;
  } kwu_cmd_t;

  // front -> queue
  typedef struct packed {
    logic     valid;
    kwu_cmd_t cmd;
  } kwu_push_t;

  // queue -> back
  typedef struct packed {
    logic     valid;
    kwu_cmd_t cmd;
  } kwu_head_t;

  // status seen by the front
  typedef struct packed {
    logic full;
    logic init_done;
  } kwu_front_stat_t;

endpackage

// File: hdl/kwu_if.sv
// ----------------------------------------------------------------------------
// kwu_in_if / kwu_out_if
// Valid/ready channels of the engine: wall items in, wall results out.
// ----------------------------------------------------------------------------
interface kwu_in_if
  import kwu_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [CELL_W-1:0] cell_a;
  logic [CELL_W-1:0] cell_b;
  logic              on_border;
  logic [TAG_W-1:0]  wall_tag;

  modport source (output valid, operation, cell_a, cell_b, on_border, wall_tag,
                  input ready);
  modport sink   (input valid, operation, cell_a, cell_b, on_border, wall_tag,
                  output ready);
endinterface

interface kwu_out_if
  import kwu_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] wall_tag_out;
  kwu_status_e      status;

  modport source (output valid, wall_tag_out, status, input ready);
  modport sink   (input valid, wall_tag_out, status, output ready);
endinterface

// File: hdl/kwu_ram.sv
// ----------------------------------------------------------------------------
// kwu_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kwu_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/kwu_front.sv
// ----------------------------------------------------------------------------
// kwu_front
// Accept wall items and classify them: restart, skipped wall (boundary or
// cell out of range) or wall to test.
// ----------------------------------------------------------------------------
module kwu_front
  import kwu_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  kwu_in_if.sink          in_i,
  input  kwu_front_stat_t stat_i,
  output kwu_push_t       push_o
);

  logic out_of_range;

  assign out_of_range = (32'(in_i.cell_a) >= 32'(NUM_CELLS)) ||
                        (32'(in_i.cell_b) >= 32'(NUM_CELLS));

  // hold off while the label memory is being cleared or the queue is full
  assign in_i.ready = stat_i.init_done && !stat_i.full;

  always_comb begin
    push_o.valid      = in_i.valid && in_i.ready;
    push_o.cmd.cell_a = in_i.cell_a;
    push_o.cmd.cell_b = in_i.cell_b;
    push_o.cmd.tag    = in_i.wall_tag;
    if (in_i.operation == OP_RESTART) begin
      push_o.cmd.kind = CMD_RESTART;
    end else if (in_i.on_border || out_of_range) begin
      push_o.cmd.kind = CMD_SKIP;
    end else begin
      push_o.cmd.kind = CMD_WALL;
    end
  end

endmodule

// File: hdl/kwu_queue.sv
// ----------------------------------------------------------------------------
// kwu_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module kwu_queue
  import kwu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kwu_push_t push_i,
  output logic      full_o,
  output kwu_head_t head_o,
  input  logic      pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  kwu_cmd_t        entry_q [QUEUE_DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CW'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = entry_q[rptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_i.cmd;
    end
  end

endmodule

// File: hdl/kwu_back.sv
// ----------------------------------------------------------------------------
// kwu_back
// Carry out commands on the label memory: clearing pass, restart sweep,
// label compare and relabel scan; hold the result in an output register.
// ----------------------------------------------------------------------------
module kwu_back
  import kwu_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF,
  localparam int AW       = $clog2(NUM_CELLS)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kwu_head_t head_i,
  output logic      pop_o,
  output logic      init_done_o,
  kwu_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_B,
    S_CMP,
    S_SCAN,
    S_SCAN_LAST,
    S_SWEEP
  } state_e;

  localparam logic [AW-1:0] LAST = AW'(NUM_CELLS - 1);

  state_e           state_q, state_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    b_q, b_d;
  logic [AW-1:0]    keep_q, keep_d;
  logic [AW-1:0]    drop_q, drop_d;
  logic [AW-1:0]    widx_q, widx_d;
  logic             pend_q, pend_d;
  logic             res_valid_q, res_valid_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic [TAG_W-1:0] res_tag_q, res_tag_d;
  kwu_status_e      res_status_q, res_status_d;

  logic             we;
  logic [AW-1:0]    waddr, wdata, raddr, rdata;
  logic             res_free;

  kwu_ram #(
    .WIDTH (AW),
    .DEPTH (NUM_CELLS)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign res_free     = !res_valid_q || out_o.ready;
  assign init_done_o  = (state_q != S_CLEAR);
  assign out_o.valid  = res_valid_q;
  assign out_o.wall_tag_out = res_tag_q;
  assign out_o.status = res_status_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    b_d          = b_q;
    keep_d       = keep_q;
    drop_d       = drop_q;
    widx_d       = widx_q;
    pend_d       = pend_q;
    tag_d        = tag_q;
    res_valid_d  = res_valid_q && !out_o.ready;
    res_tag_d    = res_tag_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = cnt_q;
    wdata        = cnt_q;
    raddr        = cnt_q;
    pop_o        = 1'b0;

    case (state_q)
      S_CLEAR, S_SWEEP: begin
        we = 1'b1;
        if (cnt_q == LAST) begin
          state_d = S_IDLE;
          if (state_q == S_SWEEP) begin
            res_valid_d  = 1'b1;
            res_tag_d    = tag_q;
            res_status_d = ST_RESTART;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        raddr = AW'(head_i.cmd.cell_a);
        if (head_i.valid && res_free) begin
          pop_o = 1'b1;
          tag_d = head_i.cmd.tag;
          b_d   = AW'(head_i.cmd.cell_b);
          case (head_i.cmd.kind)
            CMD_RESTART: begin
              cnt_d   = '0;
              state_d = S_SWEEP;
            end
            CMD_SKIP: begin
              res_valid_d  = 1'b1;
              res_tag_d    = head_i.cmd.tag;
              res_status_d = ST_BOUNDARY;
            end
            CMD_WALL: begin
              state_d = S_RD_B;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_RD_B: begin
        raddr   = b_q;
        keep_d  = rdata;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rdata == keep_q) begin
          res_valid_d  = 1'b1;
          res_tag_d    = tag_q;
          res_status_d = ST_KEPT;
          state_d      = S_IDLE;
        end else begin
          drop_d  = rdata;
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN, S_SCAN_LAST: begin
        // write back the entry read last cycle if it carries the dropped label
        waddr = widx_q;
        wdata = keep_q;
        we    = pend_q && (rdata == drop_q);
        if (state_q == S_SCAN) begin
          pend_d = 1'b1;
          widx_d = cnt_q;
          if (cnt_q == LAST) begin
            state_d = S_SCAN_LAST;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          pend_d       = 1'b0;
          res_valid_d  = 1'b1;
          res_tag_d    = tag_q;
          res_status_d = ST_MERGED;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      cnt_q        <= '0;
      b_q          <= '0;
      keep_q       <= '0;
      drop_q       <= '0;
      widx_q       <= '0;
      pend_q       <= 1'b0;
      tag_q        <= '0;
      res_valid_q  <= 1'b0;
      res_tag_q    <= '0;
      res_status_q <= ST_BOUNDARY;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      b_q          <= b_d;
      keep_q       <= keep_d;
      drop_q       <= drop_d;
      widx_q       <= widx_d;
      pend_q       <= pend_d;
      tag_q        <= tag_d;
      res_valid_q  <= res_valid_d;
      res_tag_q    <= res_tag_d;
      res_status_q <= res_status_d;
    end
  end

endmodule

// File: hdl/kruskal_wall_union_engine.sv
// ----------------------------------------------------------------------------
// kruskal_wall_union_engine
// Disjoint-set labeller for Kruskal maze generation: one group label per
// cell, walls tested and merged in arrival order.
// ----------------------------------------------------------------------------
//
//   channel | dir | transaction payload
//   --------+-----+-------------------------------------------------------
//   in_i    | in  | operation, cell_a, cell_b, on_border, wall_tag
//   out_o   | out | wall_tag_out, status (one result per input transaction)
//
// In the back part a restart is one write pass over the label RAM and a merge
// is one scan pass over its single read port; the back part takes no new
// command until it is through with the last one.
// After reset a clearing pass writes identity labels to every cell;
// in_i.ready stays low until it ends.
// The two-entry queue keeps taking transactions, until it is full, while a
// result waits on a stalled out_o; out_o holds its payload until taken.
// ----------------------------------------------------------------------------
module kruskal_wall_union_engine
  import kwu_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwu_in_if.sink    in_i,
  kwu_out_if.source out_o
);

  kwu_push_t       push;
  kwu_head_t       head;
  kwu_front_stat_t front_stat;
  logic            queue_full;
  logic            init_done;
  logic            pop;

  // merge the status the front needs into one bundle
  assign front_stat.full      = queue_full;
  assign front_stat.init_done = init_done;

  // classify incoming transactions
  kwu_front #(
    .NUM_CELLS (NUM_CELLS)
  ) u_front (
    .in_i   (in_i),
    .stat_i (front_stat),
    .push_o (push)
  );

  // decouple acceptance from the long label scans
  kwu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // execute commands against the label memory and drive results
  kwu_back #(
    .NUM_CELLS (NUM_CELLS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .init_done_o (init_done),
    .out_o       (out_o)
  );

endmodule

// File: hdl/kwu_checker.sv
// ----------------------------------------------------------------------------
// kwu_checker
// Port-level checks of the engine, attached by bind.
// ----------------------------------------------------------------------------
module kwu_checker
  import kwu_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [TAG_W-1:0] out_tag_i,
  input kwu_status_e      out_status_i
);

  logic [3:0] outstanding_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding_q <= outstanding_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      outstanding_q <= outstanding_q - 1'b1;
    end
  end

  // the clearing pass blocks input right after reset
  a_ready_low_after_reset: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $past(!rst_ni) |-> !in_ready_i
  ) else $error("input ready during clearing pass");

  // no result right after reset
  a_no_out_after_reset: assert property (
    @(posedge clk_i) disable iff (!rst_ni) $past(!rst_ni) |-> !out_valid_i
  ) else $error("result right after reset");

  // every result belongs to an accepted transaction
  a_out_has_source: assert property (
    @(posedge clk_i) disable iff (!rst_ni) out_valid_i |-> (outstanding_q != '0)
  ) else $error("result without pending transaction");

  // a stalled result holds
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_tag_i) &&
                                      $stable(out_status_i)
  ) else $error("stalled result changed");

endmodule

bind kruskal_wall_union_engine kwu_checker u_kwu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_tag_i    (out_o.wall_tag_out),
  .out_status_i (out_o.status)
);

// File: verif/kruskal_wall_union_engine_test.sv
// ----------------------------------------------------------------------------
// kruskal_wall_union_engine_test
// Self-checking bench for the wall union engine. A queue of wall and restart
// transactions feeds a clocked driver. Each accepted transaction runs through
// a local disjoint-set label model, and the model's result is queued. A
// clocked monitor compares every result against the oldest queued one.
// Source and sink idling are randomized in three phases.
// ----------------------------------------------------------------------------
module kruskal_wall_union_engine_test;
  import kwu_pkg::*;

  localparam int     NUM_CELLS  = NUM_CELLS_DEF;
  localparam int     CLK_PERIOD = 12;
  // Worst case is roughly 600 merges, each a full scan of the label RAM, plus
  // idling and the clearing pass after reset; allow several times that.
  localparam longint TIMEOUT_CYCLES = 3_000_000;

  // One input transaction. drain_first holds it back until every result
  // already owed has come out.
  typedef struct {
    logic              operation;
    logic [CELL_W-1:0] cell_a;
    logic [CELL_W-1:0] cell_b;
    logic              on_border;
    logic [TAG_W-1:0]  wall_tag;
    bit                drain_first;
  } wall_item_t;

  typedef struct {
    logic [TAG_W-1:0] wall_tag;
    kwu_status_e      status;
  } wall_result_t;

  logic clk_i;
  logic rst_ni;

  kwu_in_if  wall_in_if ();
  kwu_out_if wall_out_if ();

  kruskal_wall_union_engine #(
    .NUM_CELLS(NUM_CELLS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (wall_in_if),
    .out_o (wall_out_if)
  );

  wall_item_t   walls_to_send[$];
  wall_result_t results_due[$];

  // Group label per cell, as the engine should hold it.
  logic [CELL_W-1:0] group_of[NUM_CELLS];

  int src_idle_pct;
  int snk_idle_pct;
  int fail_count;

  // --------------------------------------------------------------------------
  // Label model: apply one accepted transaction and return its status.
  // --------------------------------------------------------------------------
  function automatic kwu_status_e resolve_wall(input wall_item_t item);
    logic [CELL_W-1:0] keep_label;
    logic [CELL_W-1:0] drop_label;
    if (item.operation == OP_RESTART) begin
      for (int i = 0; i < NUM_CELLS; i++) group_of[i] = CELL_W'(i);
      return ST_RESTART;
    end
    // Boundary flag and out-of-range cells skip the wall before any lookup.
    if (item.on_border || item.cell_a >= NUM_CELLS || item.cell_b >= NUM_CELLS)
      return ST_BOUNDARY;
    keep_label = group_of[item.cell_a];
    drop_label = group_of[item.cell_b];
    if (keep_label == drop_label) return ST_KEPT;
    // Relabel the whole group of cell_b with cell_a's label.
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (group_of[i] == drop_label) group_of[i] = keep_label;
    end
    return ST_MERGED;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, and known values on every input from time zero.
  // --------------------------------------------------------------------------
  initial begin
    clk_i                  = 1'b0;
    rst_ni                 = 1'b0;
    wall_in_if.valid       = 1'b0;
    wall_in_if.operation   = OP_RESTART;
    wall_in_if.cell_a      = '0;
    wall_in_if.cell_b      = '0;
    wall_in_if.on_border   = 1'b0;
    wall_in_if.wall_tag    = '0;
    wall_out_if.ready      = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the engine hangs or drops a result.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: present queued transactions, predict each one as it is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    wall_item_t item;
    wall_result_t due;
    if (!rst_ni) begin
      wall_in_if.valid <= 1'b0;
    end else begin
      if (wall_in_if.valid && wall_in_if.ready) begin
        item.operation   = wall_in_if.operation;
        item.cell_a      = wall_in_if.cell_a;
        item.cell_b      = wall_in_if.cell_b;
        item.on_border   = wall_in_if.on_border;
        item.wall_tag    = wall_in_if.wall_tag;
        item.drain_first = 1'b0;
        due.wall_tag     = wall_in_if.wall_tag;
        due.status       = resolve_wall(item);
        results_due.push_back(due);
      end
      // Only touch the payload when the slot is free; a held transaction
      // keeps valid high untouched.
      if (!wall_in_if.valid || wall_in_if.ready) begin
        if (walls_to_send.size() != 0 &&
            !(walls_to_send[0].drain_first && results_due.size() != 0) &&
            $urandom_range(0, 99) >= src_idle_pct) begin
          item = walls_to_send.pop_front();
          wall_in_if.valid       <= 1'b1;
          wall_in_if.operation   <= item.operation;
          wall_in_if.cell_a      <= item.cell_a;
          wall_in_if.cell_b      <= item.cell_b;
          wall_in_if.on_border   <= item.on_border;
          wall_in_if.wall_tag    <= item.wall_tag;
        end else begin
          wall_in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: randomize ready, check each result against the oldest one owed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    wall_result_t due;
    if (!rst_ni) begin
      wall_out_if.ready <= 1'b0;
    end else begin
      if (wall_out_if.valid && wall_out_if.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: wall_tag_out=%0d status=%0d",
                 wall_out_if.wall_tag_out, wall_out_if.status);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (wall_out_if.wall_tag_out !== due.wall_tag) begin
            $error("wall_tag_out mismatch: expected %0d, actual %0d",
                   due.wall_tag, wall_out_if.wall_tag_out);
            fail_count++;
          end
          if (wall_out_if.status !== due.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   due.status, wall_out_if.status);
            fail_count++;
          end
        end
      end
      wall_out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_wall(input logic op, input int a, input int b,
                            input logic bnd, input int tag,
                            input bit drain = 1'b0);
    wall_item_t item;
    item.operation   = op;
    item.cell_a      = CELL_W'(a);
    item.cell_b      = CELL_W'(b);
    item.on_border   = bnd;
    item.wall_tag    = TAG_W'(tag);
    item.drain_first = drain;
    walls_to_send.push_back(item);
  endtask

  // Wait between clock edges until every transaction is sent and answered.
  task automatic wait_drained();
    while (walls_to_send.size() != 0 || results_due.size() != 0 || wall_in_if.valid)
      @(negedge clk_i);
  endtask

  // Random mazes: restart, pick a small pool of cells anywhere in the grid,
  // then knock walls between pool cells so groups grow and later walls come
  // back as kept. Sprinkle in boundary walls, stray cells and stray restarts.
  task automatic queue_mazes(input int n_items);
    int sent;
    int pool_size;
    int n_walls;
    int pick;
    int pool[12];
    sent = 0;
    while (sent < n_items) begin
      queue_wall(OP_RESTART, $urandom_range(0, 1023), $urandom_range(0, 1023),
                 1'($urandom_range(0, 1)), $urandom_range(0, 2047));
      sent++;
      pool_size = $urandom_range(3, 10);
      for (int i = 0; i < pool_size; i++) pool[i] = $urandom_range(0, NUM_CELLS - 1);
      n_walls = $urandom_range(8, 24);
      for (int w = 0; w < n_walls && sent < n_items; w++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          queue_wall(OP_WALL, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'b1,
                     $urandom_range(0, 2047));
        end else if (pick < 13) begin
          queue_wall(OP_WALL, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     1'b0, $urandom_range(0, 2047));
        end else if (pick < 15) begin
          queue_wall(OP_RESTART, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     1'($urandom_range(0, 1)), $urandom_range(0, 2047));
        end else begin
          queue_wall(OP_WALL, pool[$urandom_range(0, pool_size - 1)],
                     pool[$urandom_range(0, pool_size - 1)], 1'b0,
                     $urandom_range(0, 2047), $urandom_range(0, 99) == 0);
        end
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    fail_count   = 0;
    src_idle_pct = 33;
    snk_idle_pct = 74;
    for (int i = 0; i < NUM_CELLS; i++) group_of[i] = CELL_W'(i);

    // Directed: restart ignores its cell and boundary fields.
    queue_wall(OP_RESTART, 1023, 1023, 1'b1, 2047);
    // Merge across the extreme cells, then see the same pair kept both ways.
    queue_wall(OP_WALL, 0, 1023, 1'b0, 0);
    queue_wall(OP_WALL, 1023, 0, 1'b0, 1);
    // Same cell on both sides is always kept.
    queue_wall(OP_WALL, 512, 512, 1'b0, 2);
    // Boundary walls skip even when the cells could merge.
    queue_wall(OP_WALL, 0, 1, 1'b1, 3);
    queue_wall(OP_WALL, 1023, 1023, 1'b1, 2047);
    // Chain merges: a group of two gets relabelled by a third cell's group.
    queue_wall(OP_WALL, 1, 2, 1'b0, 4);
    queue_wall(OP_WALL, 2, 1023, 1'b0, 5);
    queue_wall(OP_WALL, 0, 2, 1'b0, 6);
    // Alternating bit patterns in cells and tag.
    queue_wall(OP_WALL, 341, 682, 1'b0, 1365);
    queue_wall(OP_WALL, 682, 341, 1'b0, 682);
    // Restart clears the groups built above.
    queue_wall(OP_RESTART, 0, 0, 1'b0, 0);
    queue_wall(OP_WALL, 0, 1023, 1'b0, 7);
    queue_wall(OP_WALL, 0, 1, 1'b0, 8);
    queue_wall(OP_WALL, 1, 1023, 1'b0, 9);
    // Hold this restart until the engine has answered everything before it.
    queue_wall(OP_RESTART, 5, 6, 1'b0, 10, 1'b1);
    queue_wall(OP_WALL, 1023, 0, 1'b0, 11);
    queue_wall(OP_RESTART, 1023, 0, 1'b1, 12);
    queue_wall(OP_RESTART, 0, 1023, 1'b0, 13);
    wait_drained();

    // Random phases: sender idles lightly, then heavily, then not at all.
    queue_mazes(186);
    wait_drained();
    src_idle_pct = 74;
    snk_idle_pct = 33;
    queue_mazes(186);
    wait_drained();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    queue_mazes(186);
    wait_drained();

    // Let any stray result surface before judging.
    repeat (NUM_CELLS + 16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
